// File: src/clock_date_led_row_render_assert.svh
// Assertion macros for the LED row renderer checker.
`ifndef CLOCK_DATE_LED_ROW_RENDER_ASSERT_SVH
`define CLOCK_DATE_LED_ROW_RENDER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define CDLR_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("cdlr check failed");

// Next-cycle implication, sampled on i_clk, off during reset.
`define CDLR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("cdlr check failed");

`endif

// File: src/cdlr_pkg.sv
// ----------------------------------------------------------------------------
// cdlr_pkg
// Types, glyph tables and digit helpers for the clock/date LED row renderer.
// ----------------------------------------------------------------------------
package cdlr_pkg;

    typedef logic [2:0] t_row;

    typedef struct packed {
        logic [6:0] year_high;
        logic [6:0] year_low;
        logic [3:0] month;
        logic [4:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [5:0] second;
    } t_clock_state;

    localparam logic [5:0]  SEC_MAX    = 6'd59;
    localparam logic [5:0]  MIN_MAX    = 6'd59;
    localparam logic [4:0]  HOUR_MAX   = 5'd23;
    localparam logic [31:0] COLON_BITS = 32'h0018_0000;
    localparam t_row        LAST_ROW   = 3'd7;
    localparam t_row        SEC_ROW0   = 3'd3;
    localparam t_row        DATE_ROW0  = 3'd2;
    localparam t_row        DATE_ROWN  = 3'd6;
    localparam logic [3:0]  DIGIT_MAX  = 4'd9;
    localparam logic [2:0]  SMALL_ROWN = 3'd4;

    localparam logic [3:0] BIG_GLYPH [0:9][0:7] = '{
        '{4'h0, 4'hf, 4'h9, 4'h9, 4'h9, 4'h9, 4'h9, 4'hf},
        '{4'h0, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4, 4'h4},
        '{4'h0, 4'hf, 4'h1, 4'h1, 4'hf, 4'h8, 4'h8, 4'hf},
        '{4'h0, 4'hf, 4'h1, 4'h1, 4'hf, 4'h1, 4'h1, 4'hf},
        '{4'h0, 4'h9, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'h1},
        '{4'h0, 4'hf, 4'h8, 4'h8, 4'hf, 4'h1, 4'h1, 4'hf},
        '{4'h0, 4'hf, 4'h8, 4'h8, 4'hf, 4'h9, 4'h9, 4'hf},
        '{4'h0, 4'hf, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1, 4'h1},
        '{4'h0, 4'hf, 4'h9, 4'h9, 4'hf, 4'h9, 4'h9, 4'hf},
        '{4'h0, 4'hf, 4'h9, 4'h9, 4'hf, 4'h1, 4'h1, 4'hf}
    };

    localparam logic [2:0] SMALL_GLYPH [0:9][0:4] = '{
        '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
        '{3'h2, 3'h2, 3'h2, 3'h2, 3'h2},
        '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
        '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
        '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
        '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h1, 3'h1, 3'h1, 3'h1},
        '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7}
    };

    // v / 10 for v < 128 via reciprocal 205/2048
    function automatic logic [3:0] tens(input logic [6:0] v);
        logic [14:0] p;
        p = {8'b0, v} * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] ones(input logic [6:0] v);
        logic [6:0] t10;
        logic [6:0] diff;
        t10  = {3'b0, tens(v)} * 7'd10;
        diff = v - t10;
        return diff[3:0];
    endfunction

    function automatic logic [3:0] big_row(input logic [3:0] d, input t_row r);
        if (d > DIGIT_MAX) begin
            return 4'h0;
        end
        return BIG_GLYPH[d][r];
    endfunction

    function automatic logic [2:0] small_row(input logic [3:0] d, input logic [2:0] g);
        if (d > DIGIT_MAX || g > SMALL_ROWN) begin
            return 3'h0;
        end
        return SMALL_GLYPH[d][g];
    endfunction

endpackage

// File: src/cdlr_clock.sv
// ----------------------------------------------------------------------------
// cdlr_clock
// Time and date registers: on accept, load on sync, else advance one second.
// ----------------------------------------------------------------------------
module cdlr_clock (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic                  i_sync_valid,
    input  cdlr_pkg::t_clock_state i_sync,
    output cdlr_pkg::t_clock_state o_state
);

    cdlr_pkg::t_clock_state r_state;
    cdlr_pkg::t_clock_state n_state;

    always_comb begin
        n_state = r_state;
        if (i_sync_valid) begin
            n_state = i_sync;
        end else if (r_state.second >= cdlr_pkg::SEC_MAX) begin
            n_state.second = '0;
            if (r_state.minute >= cdlr_pkg::MIN_MAX) begin
                n_state.minute = '0;
                if (r_state.hour >= cdlr_pkg::HOUR_MAX) begin
                    n_state.hour = '0;
                end else begin
                    n_state.hour = r_state.hour + 5'd1;
                end
            end else begin
                n_state.minute = r_state.minute + 6'd1;
            end
        end else begin
            n_state.second = r_state.second + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_accept) begin
            r_state <= n_state;
        end
    end

    assign o_state = r_state;

endmodule

// File: src/cdlr_render.sv
// ----------------------------------------------------------------------------
// cdlr_render
// Builds the time and date bitmaps of one display row.
// ----------------------------------------------------------------------------
module cdlr_render (
    input  cdlr_pkg::t_clock_state i_state,
    input  cdlr_pkg::t_row         i_row,
    output logic [31:0]            o_time_row,
    output logic [31:0]            o_date_row
);

    logic [2:0]  w_sec_g;
    logic [2:0]  w_date_g;
    logic [31:0] w_time;
    logic [31:0] w_date;

    assign w_sec_g  = i_row - cdlr_pkg::SEC_ROW0;
    assign w_date_g = i_row - cdlr_pkg::DATE_ROW0;

    always_comb begin
        w_time = '0;
        w_time[30:27] = cdlr_pkg::big_row(cdlr_pkg::tens({2'b0, i_state.hour}), i_row);
        w_time[25:22] = cdlr_pkg::big_row(cdlr_pkg::ones({2'b0, i_state.hour}), i_row);
        w_time[17:14] = cdlr_pkg::big_row(cdlr_pkg::tens({1'b0, i_state.minute}), i_row);
        w_time[12:9]  = cdlr_pkg::big_row(cdlr_pkg::ones({1'b0, i_state.minute}), i_row);
        if (i_row >= cdlr_pkg::SEC_ROW0) begin
            w_time[7:5] = cdlr_pkg::small_row(cdlr_pkg::tens({1'b0, i_state.second}),
                                              w_sec_g);
            w_time[3:1] = cdlr_pkg::small_row(cdlr_pkg::ones({1'b0, i_state.second}),
                                              w_sec_g);
        end
        if (i_row == 3'd2 || i_row == 3'd3 || i_row == 3'd5 || i_row == 3'd6) begin
            w_time = w_time | cdlr_pkg::COLON_BITS;
        end
    end

    always_comb begin
        w_date = '0;
        if (i_row >= cdlr_pkg::DATE_ROW0 && i_row <= cdlr_pkg::DATE_ROWN) begin
            w_date[30:28] = cdlr_pkg::small_row(cdlr_pkg::tens(i_state.year_high), w_date_g);
            w_date[26:24] = cdlr_pkg::small_row(cdlr_pkg::ones(i_state.year_high), w_date_g);
            w_date[22:20] = cdlr_pkg::small_row(cdlr_pkg::tens(i_state.year_low), w_date_g);
            w_date[18:16] = cdlr_pkg::small_row(cdlr_pkg::ones(i_state.year_low), w_date_g);
            w_date[14:12] = cdlr_pkg::small_row(cdlr_pkg::tens({3'b0, i_state.month}),
                                                w_date_g);
            w_date[10:8]  = cdlr_pkg::small_row(cdlr_pkg::ones({3'b0, i_state.month}),
                                                w_date_g);
            w_date[6:4]   = cdlr_pkg::small_row(cdlr_pkg::tens({2'b0, i_state.day}),
                                                w_date_g);
            w_date[2:0]   = cdlr_pkg::small_row(cdlr_pkg::ones({2'b0, i_state.day}),
                                                w_date_g);
        end
    end

    assign o_time_row = w_time;
    assign o_date_row = w_date;

endmodule

// File: src/clock_date_led_row_render.sv
// ----------------------------------------------------------------------------
// clock_date_led_row_render
// Flow: a taken item loads the row counter; rows are then registered out.
// Rows: one row a cycle from the row counter, unless the output stalls.
// Reset: synchronous, clears time, date, row counter and output valid.
// ----------------------------------------------------------------------------
module clock_date_led_row_render (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_sync_valid,
    input  logic [6:0]  i_sync_year_high,
    input  logic [6:0]  i_sync_year_low,
    input  logic [3:0]  i_sync_month,
    input  logic [4:0]  i_sync_day,
    input  logic [4:0]  i_sync_hour,
    input  logic [5:0]  i_sync_minute,
    input  logic [5:0]  i_sync_second,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_row_number,
    output logic [31:0] o_time_row,
    output logic [31:0] o_date_row,
    output logic        o_last_row
);

    cdlr_pkg::t_clock_state w_sync;
    cdlr_pkg::t_clock_state w_state;
    logic [31:0]            w_time_row;
    logic [31:0]            w_date_row;
    logic                   w_load;
    logic                   w_emit;
    logic                   w_last;
    logic                   w_accept;

    logic                   r_busy;
    cdlr_pkg::t_row         r_row;
    logic                   r_out_valid;
    logic [3:0]             r_row_number;
    logic [31:0]            r_time_row;
    logic [31:0]            r_date_row;
    logic                   r_last_row;

    assign w_sync = '{year_high: i_sync_year_high, year_low: i_sync_year_low,
                      month: i_sync_month, day: i_sync_day, hour: i_sync_hour,
                      minute: i_sync_minute, second: i_sync_second};

    assign w_load     = !r_out_valid || !i_out_stall;
    assign w_emit     = r_busy && w_load;
    assign w_last     = (r_row == cdlr_pkg::LAST_ROW);
    // next item may enter as the last row of the frame goes out
    assign o_in_stall = r_busy && !(w_emit && w_last);
    assign w_accept   = i_in_valid && !o_in_stall;

    cdlr_clock u_clock (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_accept     (w_accept),
        .i_sync_valid (i_sync_valid),
        .i_sync       (w_sync),
        .o_state      (w_state)
    );

    cdlr_render u_render (
        .i_state    (w_state),
        .i_row      (r_row),
        .o_time_row (w_time_row),
        .o_date_row (w_date_row)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_row       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_row  <= '0;
            end else if (w_emit) begin
                r_busy <= !w_last;
                r_row  <= r_row + 3'd1;
            end
            if (w_load) begin
                r_out_valid <= w_emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_row_number <= {1'b0, r_row} + 4'd1;
            r_time_row   <= w_time_row;
            r_date_row   <= w_date_row;
            r_last_row   <= w_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_row_number = r_row_number;
    assign o_time_row   = r_time_row;
    assign o_date_row   = r_date_row;
    assign o_last_row   = r_last_row;

endmodule

// File: src/cdlr_checker.sv
// ----------------------------------------------------------------------------
// cdlr_checker
// Port-level checks on row order, frame end, input back-pressure and output hold.
// ----------------------------------------------------------------------------
`include "clock_date_led_row_render_assert.svh"

module cdlr_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [3:0]  o_row_number,
    input logic [31:0] o_time_row,
    input logic [31:0] o_date_row,
    input logic        o_last_row
);

    logic        w_row_take;
    logic        w_row_held;
    logic [3:0]  w_next_row;
    logic [68:0] w_out_word;

    assign w_row_take = o_out_valid && !i_out_stall && !o_last_row;
    assign w_row_held = o_out_valid && i_out_stall;
    assign w_next_row = o_row_number + 4'd1;
    assign w_out_word = {o_row_number, o_time_row, o_date_row, o_last_row};

    `CDLR_ASSERT_NOW(a_last_is_row8, o_out_valid && o_last_row, o_row_number == 4'd8)

    `CDLR_ASSERT_NEXT(a_rows_in_order, w_row_take, o_out_valid && o_row_number == $past(w_next_row))

    `CDLR_ASSERT_NOW(a_busy_stalls_in, o_out_valid && o_row_number < 4'd7, o_in_stall)

    `CDLR_ASSERT_NEXT(a_out_hold, w_row_held, o_out_valid && $stable(w_out_word))

endmodule

bind clock_date_led_row_render cdlr_checker u_cdlr_checker (.*);
